### rtl/coq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coq_pkg: shared types and constants for the current on/off qualifier
// Phase codes, configuration register map, reset values and field widths.
// ----------------------------------------------------------------------------
package coq_pkg;

  // field widths
  localparam int unsigned CurWidth   = 16;
  localparam int unsigned TimeWidth  = 32;
  localparam int unsigned PhaseWidth = 2;
  localparam int unsigned AddrWidth  = 4;
  localparam int unsigned DataWidth  = 32;

  // packed stream widths, padded to whole bytes
  localparam int unsigned InDataWidth  = 48;
  localparam int unsigned OutDataWidth = 8;

  // register reset values (30 mA thresholds, 15 s off dwell)
  localparam logic [CurWidth-1:0]  OnThresholdRst  = CurWidth'(30);
  localparam logic [CurWidth-1:0]  OffThresholdRst = CurWidth'(30);
  localparam logic [TimeWidth-1:0] OnDwellRst      = TimeWidth'(0);
  localparam logic [TimeWidth-1:0] OffDwellRst     = TimeWidth'(15000);

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    RegOnThreshold  = 2'd0,
    RegOffThreshold = 2'd1,
    RegOnDwell      = 2'd2,
    RegOffDwell     = 2'd3
  } reg_idx_e;

  // qualifier phase
  typedef enum logic [PhaseWidth-1:0] {
    PhOffStable  = 2'd0,
    PhOffPending = 2'd1,
    PhOnStable   = 2'd2,
    PhOnPending  = 2'd3
  } phase_e;

  // configuration handed from the register block to the datapath
  typedef struct packed {
    logic [CurWidth-1:0]  on_threshold;
    logic [CurWidth-1:0]  off_threshold;
    logic [TimeWidth-1:0] on_dwell_ms;
    logic [TimeWidth-1:0] off_dwell_ms;
  } cfg_t;

endpackage

### rtl/coq_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coq_regs: configuration register file
// APB slave holding thresholds and dwell times; zero wait states.
// ----------------------------------------------------------------------------
module coq_regs
  import coq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_e'(paddr[3:2]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_threshold  <= OnThresholdRst;
      cfg_q.off_threshold <= OffThresholdRst;
      cfg_q.on_dwell_ms   <= OnDwellRst;
      cfg_q.off_dwell_ms  <= OffDwellRst;
    end else if (wr_en) begin
      unique case (idx)
        RegOnThreshold:  cfg_q.on_threshold  <= pwdata[CurWidth-1:0];
        RegOffThreshold: cfg_q.off_threshold <= pwdata[CurWidth-1:0];
        RegOnDwell:      cfg_q.on_dwell_ms   <= pwdata[TimeWidth-1:0];
        RegOffDwell:     cfg_q.off_dwell_ms  <= pwdata[TimeWidth-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      RegOnThreshold:  prdata = DataWidth'(cfg_q.on_threshold);
      RegOffThreshold: prdata = DataWidth'(cfg_q.off_threshold);
      RegOnDwell:      prdata = DataWidth'(cfg_q.on_dwell_ms);
      RegOffDwell:     prdata = DataWidth'(cfg_q.off_dwell_ms);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/current_on_off_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// current_on_off_qualifier: on/off detector with dwell-time debounce
// Pipeline: input register, then result register. Throughput: one beat per
// cycle unless m_axis_tready stalls the result; the phase and start-time
// update is one subtract and compare between the input and result registers.
// Reset: phase off stable, both start times zero, registers at their defaults.
// ----------------------------------------------------------------------------
module current_on_off_qualifier
  import coq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input stream
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // tdata: [15:0] sample_ma, [47:16] now_ms
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  // tuser: [0] initialize
  input  logic                    s_axis_tuser,
  // result stream
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // tdata: [0] is_on, [2:1] phase_code, [3] report, [7:4] zero
  output logic [OutDataWidth-1:0] m_axis_tdata,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrWidth-1:0]    paddr,
  input  logic [DataWidth-1:0]    pwdata,
  output logic [DataWidth-1:0]    prdata,
  output logic                    pready
);

  cfg_t cfg;

  coq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // pipeline control
  logic in_vld_q;
  logic out_vld_q;
  logic out_free;
  logic step_en;

  assign out_free      = ~out_vld_q | m_axis_tready;
  assign step_en       = in_vld_q & out_free;
  assign s_axis_tready = ~in_vld_q | step_en;

  // input register
  logic [CurWidth-1:0]  sample_q;
  logic [TimeWidth-1:0] now_q;
  logic                 init_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sample_q <= s_axis_tdata[CurWidth-1:0];
      now_q    <= s_axis_tdata[CurWidth+TimeWidth-1:CurWidth];
      init_q   <= s_axis_tuser;
    end
  end

  // qualifier state
  phase_e               phase_q, phase_d;
  logic [TimeWidth-1:0] rise_start_q, rise_start_d;
  logic [TimeWidth-1:0] fall_start_q, fall_start_d;
  logic                 report;

  // level and dwell checks
  logic above_on;
  logic below_off;
  logic rise_done;
  logic fall_done;

  assign above_on  = sample_q > cfg.on_threshold;
  assign below_off = sample_q < cfg.off_threshold;
  assign rise_done = (now_q - rise_start_q) > cfg.on_dwell_ms;
  assign fall_done = (now_q - fall_start_q) > cfg.off_dwell_ms;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (init_q) begin
      phase_d = below_off ? PhOffStable : PhOnStable;
    end else begin
      unique case (phase_q)
        PhOffStable: begin
          if (above_on) begin
            phase_d = (cfg.on_dwell_ms != '0) ? PhOffPending : PhOnStable;
          end
        end
        PhOffPending: begin
          if (!above_on) begin
            phase_d = PhOffStable;
          end else if (rise_done) begin
            phase_d = PhOnStable;
          end
        end
        PhOnStable: begin
          if (below_off) begin
            phase_d = (cfg.off_dwell_ms != '0) ? PhOnPending : PhOffStable;
          end
        end
        PhOnPending: begin
          if (!below_off) begin
            phase_d = PhOnStable;
          end else if (fall_done) begin
            phase_d = PhOffStable;
          end
        end
        default: phase_d = PhOffStable;
      endcase
    end
  end

  // report flag and start times
  always_comb begin
    report       = 1'b0;
    rise_start_d = rise_start_q;
    fall_start_d = fall_start_q;
    if (init_q) begin
      rise_start_d = '0;
      fall_start_d = '0;
    end else begin
      unique case (phase_q)
        PhOffStable: begin
          if (above_on) begin
            if (cfg.on_dwell_ms != '0) begin
              rise_start_d = now_q;
            end else begin
              report = 1'b1;
            end
          end
        end
        PhOffPending: report = above_on & rise_done;
        PhOnStable: begin
          if (below_off) begin
            if (cfg.off_dwell_ms != '0) begin
              fall_start_d = now_q;
            end else begin
              report = 1'b1;
            end
          end
        end
        PhOnPending: report = below_off & fall_done;
        default: report = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhOffStable;
      rise_start_q <= '0;
      fall_start_q <= '0;
    end else if (step_en) begin
      phase_q      <= phase_d;
      rise_start_q <= rise_start_d;
      fall_start_q <= fall_start_d;
    end
  end

  // result register
  logic [PhaseWidth-1:0] res_phase_q;
  logic                  res_report_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_phase_q  <= phase_d;
      res_report_q <= report;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, res_report_q, res_phase_q, res_phase_q[1]};

endmodule
